// File: design/rwla_pkg.sv
// ----------------------------------------------------------------------------
// Reader-writer lock arbiter package
// Shared sizes, request and event codes, and ring pointer helper.
// ----------------------------------------------------------------------------
package rwla_pkg;

  // Writer ring sizing.
  localparam int RING_DEPTH = 16;
  localparam int RING_AW    = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
  localparam int FILL_W     = $clog2(RING_DEPTH + 1);

  // Reader count limit, capped by the 8-bit reader counter.
  localparam int          READER_LIMIT = 255;
  localparam logic [7:0]  READER_CAP   = (READER_LIMIT > 255) ? 8'd255 : 8'(READER_LIMIT);

  // Payload widths.
  localparam int ID_W    = 8;
  localparam int CNT_W   = 8;
  localparam int MODE_W  = 2;
  localparam int EVENT_W = 3;

  // Request codes.
  typedef enum logic [MODE_W-1:0] {
    MODE_RD_LOCK   = 2'd0,
    MODE_RD_UNLOCK = 2'd1,
    MODE_WR_LOCK   = 2'd2,
    MODE_WR_UNLOCK = 2'd3
  } mode_t;

  // Result event codes.
  typedef enum logic [EVENT_W-1:0] {
    EV_NONE    = 3'd0,
    EV_GRANTED = 3'd1,
    EV_READERS = 3'd2,
    EV_WRITER  = 3'd3,
    EV_ERROR   = 3'd4
  } event_t;

  // Advance a ring pointer with wrap at the ring depth.
  function automatic logic [RING_AW-1:0] ring_next(input logic [RING_AW-1:0] idx);
    logic [RING_AW-1:0] res;
    if (idx == RING_AW'(RING_DEPTH - 1)) begin
      res = '0;
    end else begin
      res = idx + RING_AW'(1);
    end
    return res;
  endfunction

endpackage

// File: design/rwla_ram.sv
// ----------------------------------------------------------------------------
// Generic single-port-write, single-port-read RAM
// One write and one registered read per cycle; no reset on contents.
// ----------------------------------------------------------------------------
module rwla_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                       wr_data,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                       rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// File: design/rwla_engine.sv
// ----------------------------------------------------------------------------
// Reader-writer lock engine
// Holds the lock counters and ring pointers, reads the front writer from the
// ring memory, applies one request and registers its result event.
// ----------------------------------------------------------------------------
module rwla_engine (
  input  logic                          clk,
  input  logic                          rst_n,
  // Request channel.
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [rwla_pkg::MODE_W-1:0]   in_mode,
  input  logic [rwla_pkg::ID_W-1:0]     in_requester_id,
  // Result channel.
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [rwla_pkg::EVENT_W-1:0]  out_event_res,
  output logic [rwla_pkg::ID_W-1:0]     out_granted_writer,
  output logic [rwla_pkg::CNT_W-1:0]    out_released_readers,
  // Ring memory port.
  output logic                          ram_wr_en,
  output logic [rwla_pkg::RING_AW-1:0]  ram_wr_addr,
  output logic [rwla_pkg::ID_W-1:0]     ram_wr_data,
  output logic [rwla_pkg::RING_AW-1:0]  ram_rd_addr,
  input  logic [rwla_pkg::ID_W-1:0]     ram_rd_data
);

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_t;

  state_t                         state_r,   state_nxt;
  logic                           holds_r,   holds_nxt;
  logic [rwla_pkg::CNT_W-1:0]     total_r,   total_nxt;
  logic [rwla_pkg::CNT_W-1:0]     waiting_r, waiting_nxt;
  logic [rwla_pkg::RING_AW-1:0]   head_r,    head_nxt;
  logic [rwla_pkg::RING_AW-1:0]   tail_r,    tail_nxt;
  logic [rwla_pkg::FILL_W-1:0]    fill_r,    fill_nxt;
  logic                           ovalid_r,  ovalid_nxt;
  rwla_pkg::event_t               event_r,   event_nxt;
  logic [rwla_pkg::ID_W-1:0]      gw_r,      gw_nxt;
  logic [rwla_pkg::CNT_W-1:0]     rel_r,     rel_nxt;
  rwla_pkg::mode_t                mode_r,    mode_nxt;
  logic [rwla_pkg::ID_W-1:0]      id_r,      id_nxt;

  logic                           commit;
  logic [rwla_pkg::ID_W-1:0]      front_id;
  logic [rwla_pkg::CNT_W-1:0]     total_dec;

  // The read port always points at the front of the ring; the head only
  // moves on a commit, so the registered data stays current during a stall.
  assign ram_rd_addr = head_r;
  assign ram_wr_addr = tail_r;
  assign ram_wr_data = id_r;

  assign in_ready             = (state_r == S_IDLE);
  assign out_valid            = ovalid_r;
  assign out_event_res        = event_r;
  assign out_granted_writer   = gw_r;
  assign out_released_readers = rel_r;

  // A request is applied once the result register is free.
  assign commit    = (state_r == S_EXEC) && (!ovalid_r || out_ready);
  assign total_dec = total_r - rwla_pkg::CNT_W'(1);

  // On a write lock into an empty ring the new writer is the front itself.
  assign front_id = (fill_r == '0) ? id_r : ram_rd_data;

  // Request decode and state update.
  always_comb begin
    state_nxt   = state_r;
    holds_nxt   = holds_r;
    total_nxt   = total_r;
    waiting_nxt = waiting_r;
    head_nxt    = head_r;
    tail_nxt    = tail_r;
    fill_nxt    = fill_r;
    ovalid_nxt  = ovalid_r;
    event_nxt   = event_r;
    gw_nxt      = gw_r;
    rel_nxt     = rel_r;
    mode_nxt    = mode_r;
    id_nxt      = id_r;
    ram_wr_en   = 1'b0;

    // Retire a result transfer.
    if (ovalid_r && out_ready) begin
      ovalid_nxt = 1'b0;
    end

    // Capture a request transfer.
    if ((state_r == S_IDLE) && in_valid) begin
      mode_nxt  = rwla_pkg::mode_t'(in_mode);
      id_nxt    = in_requester_id;
      state_nxt = S_EXEC;
    end

    if (commit) begin
      state_nxt  = S_IDLE;
      ovalid_nxt = 1'b1;
      event_nxt  = rwla_pkg::EV_NONE;
      gw_nxt     = '0;
      rel_nxt    = '0;
      case (mode_r)
        rwla_pkg::MODE_RD_LOCK: begin
          if (total_r >= rwla_pkg::READER_CAP) begin
            event_nxt = rwla_pkg::EV_ERROR;
          end else begin
            total_nxt = total_r + rwla_pkg::CNT_W'(1);
            if (holds_r) begin
              waiting_nxt = waiting_r + rwla_pkg::CNT_W'(1);
            end else begin
              event_nxt = rwla_pkg::EV_GRANTED;
            end
          end
        end
        rwla_pkg::MODE_RD_UNLOCK: begin
          if (total_r <= waiting_r) begin
            event_nxt = rwla_pkg::EV_ERROR;
          end else begin
            total_nxt = total_dec;
            // The last reader out hands the lock to the front writer.
            if ((fill_r != '0) && (total_dec == '0) && !holds_r) begin
              gw_nxt    = ram_rd_data;
              head_nxt  = rwla_pkg::ring_next(head_r);
              fill_nxt  = fill_r - rwla_pkg::FILL_W'(1);
              holds_nxt = 1'b1;
              event_nxt = rwla_pkg::EV_WRITER;
            end
          end
        end
        rwla_pkg::MODE_WR_LOCK: begin
          if (fill_r == rwla_pkg::FILL_W'(rwla_pkg::RING_DEPTH)) begin
            event_nxt = rwla_pkg::EV_ERROR;
          end else begin
            ram_wr_en = 1'b1;
            tail_nxt  = rwla_pkg::ring_next(tail_r);
            // Enqueue and immediate grant leave the fill count unchanged.
            if ((total_r == '0) && !holds_r) begin
              gw_nxt    = front_id;
              head_nxt  = rwla_pkg::ring_next(head_r);
              holds_nxt = 1'b1;
              event_nxt = rwla_pkg::EV_GRANTED;
            end else begin
              fill_nxt = fill_r + rwla_pkg::FILL_W'(1);
            end
          end
        end
        rwla_pkg::MODE_WR_UNLOCK: begin
          if (!holds_r) begin
            event_nxt = rwla_pkg::EV_ERROR;
          end else begin
            holds_nxt = 1'b0;
            // Waiting readers go before any queued writer.
            if (waiting_r != '0) begin
              rel_nxt     = waiting_r;
              waiting_nxt = '0;
              event_nxt   = rwla_pkg::EV_READERS;
            end else if ((fill_r != '0) && (total_r == '0)) begin
              gw_nxt    = ram_rd_data;
              head_nxt  = rwla_pkg::ring_next(head_r);
              fill_nxt  = fill_r - rwla_pkg::FILL_W'(1);
              holds_nxt = 1'b1;
              event_nxt = rwla_pkg::EV_WRITER;
            end
          end
        end
        default: begin
          event_nxt = rwla_pkg::EV_ERROR;
        end
      endcase
    end
  end

  // State, counters, pointers and the result register.
  always_ff @(posedge clk) begin
    mode_r  <= mode_nxt;
    id_r    <= id_nxt;
    event_r <= event_nxt;
    gw_r    <= gw_nxt;
    rel_r   <= rel_nxt;
    if (!rst_n) begin
      state_r   <= S_IDLE;
      holds_r   <= 1'b0;
      total_r   <= '0;
      waiting_r <= '0;
      head_r    <= '0;
      tail_r    <= '0;
      fill_r    <= '0;
      ovalid_r  <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      holds_r   <= holds_nxt;
      total_r   <= total_nxt;
      waiting_r <= waiting_nxt;
      head_r    <= head_nxt;
      tail_r    <= tail_nxt;
      fill_r    <= fill_nxt;
      ovalid_r  <= ovalid_nxt;
    end
  end

endmodule

// File: design/reader_writer_lock_arbiter.sv
// ----------------------------------------------------------------------------
// Reader-writer lock arbiter
// Lock manager with counted readers and a FIFO ring of waiting writers.
// ----------------------------------------------------------------------------
// Each request (read lock, read unlock, write lock, write unlock) yields one
// result event. A request passes a transfer step, in which the front of the
// writer ring is read from the ring memory, and then an execute step, in
// which the registered read data is used and the state and ring are
// updated. The registered read port of the ring memory makes the execute
// step a separate one. A finished result sits in an output register, so
// the next request is taken while it waits; the execute step holds only
// while that register is still full. Unlock without a holder, a full ring
// and a full reader count answer with the error event and change nothing.
module reader_writer_lock_arbiter (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [rwla_pkg::MODE_W-1:0]   in_mode,
  input  logic [rwla_pkg::ID_W-1:0]     in_requester_id,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [rwla_pkg::EVENT_W-1:0]  out_event_res,
  output logic [rwla_pkg::ID_W-1:0]     out_granted_writer,
  output logic [rwla_pkg::CNT_W-1:0]    out_released_readers
);

  logic                         ram_wr_en;
  logic [rwla_pkg::RING_AW-1:0] ram_wr_addr;
  logic [rwla_pkg::ID_W-1:0]    ram_wr_data;
  logic [rwla_pkg::RING_AW-1:0] ram_rd_addr;
  logic [rwla_pkg::ID_W-1:0]    ram_rd_data;

  // Lock state and request sequencing.
  rwla_engine u_engine (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_ready             (in_ready),
    .in_mode              (in_mode),
    .in_requester_id      (in_requester_id),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_event_res        (out_event_res),
    .out_granted_writer   (out_granted_writer),
    .out_released_readers (out_released_readers),
    .ram_wr_en            (ram_wr_en),
    .ram_wr_addr          (ram_wr_addr),
    .ram_wr_data          (ram_wr_data),
    .ram_rd_addr          (ram_rd_addr),
    .ram_rd_data          (ram_rd_data)
  );

  // Ring of queued writer ids.
  rwla_ram #(
    .WIDTH (rwla_pkg::ID_W),
    .DEPTH (rwla_pkg::RING_DEPTH)
  ) u_ring (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

endmodule
